/* src/dssd_pkg.sv */
// Shared constants and the segment table for the decimal seven-segment shift driver.
// No dependencies; imported by dssd_digit and the top level.
package dssd_pkg;

    localparam int DIGITS      = 4;
    localparam int DIGIT_W     = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int VALUE_W     = 16;
    localparam int WORD_BITS   = 16;
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int SEL_W       = 4;

    // Reciprocal of ten for a 16-bit dividend: q = (n * RECIP_10) >> RECIP_SHIFT
    localparam int RECIP_W     = 17;
    localparam int PROD_W      = VALUE_W + RECIP_W;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP_10 = 17'h0CCCD;

    localparam logic [WORD_BITS-1:0] SEG_INVERT = 16'hFF00;
    localparam logic [BIT_W-1:0]     LAST_BIT   = BIT_W'(WORD_BITS - 1);
    localparam logic [DIGIT_W-1:0]   LAST_DIGIT = DIGIT_W'(DIGITS - 1);

    // Segment pattern of one decimal digit, held in the upper byte
    function automatic logic [WORD_BITS-1:0] seg_pattern(input logic [3:0] digit);
        logic [WORD_BITS-1:0] pat;
        begin
            case (digit)
                4'd0:    pat = 16'hFC00;
                4'd1:    pat = 16'h6000;
                4'd2:    pat = 16'hDA00;
                4'd3:    pat = 16'hF200;
                4'd4:    pat = 16'h6600;
                4'd5:    pat = 16'hB600;
                4'd6:    pat = 16'hBE00;
                4'd7:    pat = 16'hE000;
                4'd8:    pat = 16'hFE00;
                4'd9:    pat = 16'hF600;
                default: pat = 16'h0000;
            endcase
            return pat;
        end
    endfunction

endpackage

/* src/dssd_digit.sv */
// Splits off the lowest decimal digit of a value and forms its 16-bit display word.
// Depends on dssd_pkg for widths, the reciprocal of ten and the segment table.
module dssd_digit
    import dssd_pkg::*;
(
    input  logic [VALUE_W-1:0]   num,
    input  logic [DIGIT_W-1:0]   pos,
    output logic [VALUE_W-1:0]   quot,
    output logic [WORD_BITS-1:0] word
);

    logic [PROD_W-1:0]    prod;
    logic [VALUE_W-1:0]   times_ten;
    logic [VALUE_W-1:0]   diff;
    logic [3:0]           rem;
    logic [SEL_W-1:0]     sel;

    // Divide by ten through the reciprocal, then recover the remainder
    always_comb
    begin
        prod      = PROD_W'(num) * PROD_W'(RECIP_10);
        quot      = VALUE_W'(prod >> RECIP_SHIFT);
        times_ten = (quot << 3) + (quot << 1);
        diff      = num - times_ten;
        rem       = diff[3:0];
    end

    // Segment pattern with one-hot digit select, segments active low
    always_comb
    begin
        sel  = SEL_W'(1) << 2'(pos);
        word = (seg_pattern(rem) | WORD_BITS'(sel)) ^ SEG_INVERT;
    end

endmodule

/* src/decimal_seven_segment_shift_driver_unit.sv */
// Top level of the decimal seven-segment shift driver.
// Depends on dssd_pkg and dssd_digit.
//
// Usage:
//   Raise start with a 16-bit value while busy is low; the value is taken at that
//   clock edge. Its lowest four decimal digits are sent units first, each as a
//   16-bit word shifted out least significant bit first, one bit per cycle.
//   Every bit appears on serial_data for one cycle with strobe high; store_pulse
//   marks bit 15 of each word and last marks bit 15 of the final word.
//   Latency: the first bit appears in the cycle after the accepting edge.
//   A value is sent as 4 words of 16 bits through the one-bit serial output.
//   busy drops during the final bit, so a start in that cycle makes the next
//   value's first bit follow with no gap.
//   Each new digit is taken from the running quotient by one reciprocal
//   multiply shared between the load and the digit advance.
//   Reset clears the sequencer: strobe and busy go low, no bit is sent.
//   The receiver cannot stall: each bit is shown exactly once for one cycle.
module decimal_seven_segment_shift_driver_unit
    import dssd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [VALUE_W-1:0] value,
    output logic               busy,
    output logic               strobe,
    output logic               serial_data,
    output logic               store_pulse,
    output logic               last
);

    logic                 active_reg, active_next;
    logic [DIGIT_W-1:0]   dig_reg, dig_next;
    logic [BIT_W-1:0]     bit_reg, bit_next;
    logic [VALUE_W-1:0]   num_reg, num_next;
    logic [WORD_BITS-1:0] word_reg, word_next;

    logic                 word_end;
    logic                 final_bit;
    logic                 accept;
    logic [VALUE_W-1:0]   div_num;
    logic [DIGIT_W-1:0]   div_pos;
    logic [VALUE_W-1:0]   div_quot;
    logic [WORD_BITS-1:0] div_word;

    // Beat bookkeeping
    always_comb
    begin
        word_end  = active_reg && (bit_reg == LAST_BIT);
        final_bit = word_end && (dig_reg == LAST_DIGIT);
        busy      = active_reg && !final_bit;
        accept    = start && !busy;
    end

    // Share one digit unit between loading a value and moving to the next digit
    always_comb
    begin
        if (accept)
        begin
            div_num = value;
            div_pos = '0;
        end
        else
        begin
            div_num = num_reg;
            div_pos = dig_reg + DIGIT_W'(1);
        end
    end

    dssd_digit u_digit (
        .num  (div_num),
        .pos  (div_pos),
        .quot (div_quot),
        .word (div_word)
    );

    // Load, shift or advance the word under transmission
    always_comb
    begin
        active_next = active_reg;
        dig_next    = dig_reg;
        bit_next    = bit_reg;
        num_next    = num_reg;
        word_next   = word_reg;
        if (accept)
        begin
            active_next = 1'b1;
            dig_next    = '0;
            bit_next    = '0;
            num_next    = div_quot;
            word_next   = div_word;
        end
        else if (final_bit)
        begin
            active_next = 1'b0;
        end
        else if (word_end)
        begin
            dig_next  = div_pos;
            bit_next  = '0;
            num_next  = div_quot;
            word_next = div_word;
        end
        else if (active_reg)
        begin
            bit_next  = bit_reg + BIT_W'(1);
            word_next = word_reg >> 1;
        end
    end

    // Hold the sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            dig_reg    <= '0;
            bit_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            dig_reg    <= dig_next;
            bit_reg    <= bit_next;
        end
    end

    // Hold the payload
    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        word_reg <= word_next;
    end

    // Drive the result beat from registers
    always_comb
    begin
        strobe      = active_reg;
        serial_data = word_reg[0];
        store_pulse = word_end;
        last        = final_bit;
    end

endmodule
